>>> rtl/dge_pkg.sv
package dge_pkg;

    // Frame geometry and field widths
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 9;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int CFG_IDX_W  = 2;

    // Arithmetic widths: one squared channel difference, one gradient pair,
    // the full gradient sum and its square root.
    localparam int SQ_W       = 2 * CH_W;
    localparam int PAIR_W     = SQ_W + 2;
    localparam int SUM_W      = PAIR_W + 1;
    localparam int ROOT_W     = 10;
    localparam int ENERGY_W   = 6;

    // Division by ten of the root: multiply by 205 and drop 11 bits.
    localparam int DIV10_MUL_W = 8;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 8'd205;
    localparam int DIV10_SHIFT = 11;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_idx_t;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    // Work handed to the back part
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_ZERO  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_FETCH = 2'd1,
        B_SQRT  = 2'd2,
        B_OUT   = 2'd3
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row_up;
        logic [ROW_W-1:0] row_down;
        logic [COL_W-1:0] col_left;
        logic [COL_W-1:0] col_right;
        logic [PIX_W-1:0] pixel;
    } queue_item_t;

endpackage

>>> rtl/dge_front.sv
module dge_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dge_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dge_pkg::DIM_W-1:0]           cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [dge_pkg::ROW_W-1:0]           s_row,
    input  logic [dge_pkg::COL_W-1:0]           s_col,
    input  logic [dge_pkg::CH_W-1:0]            s_red,
    input  logic [dge_pkg::CH_W-1:0]            s_green,
    input  logic [dge_pkg::CH_W-1:0]            s_blue,
    output logic                                q_push,
    output dge_pkg::queue_item_t                q_item,
    input  logic                                q_full
);

    logic [dge_pkg::DIM_W-1:0] frame_width_reg;
    logic [dge_pkg::DIM_W-1:0] frame_height_reg;
    logic [dge_pkg::DIM_W-1:0] width_eff;
    logic [dge_pkg::DIM_W-1:0] height_eff;
    logic [dge_pkg::DIM_W-1:0] width_last;
    logic [dge_pkg::DIM_W-1:0] height_last;
    logic                      in_frame;
    logic                      keep;

    // Frame size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= dge_pkg::DIM_W'(dge_pkg::MAX_WIDTH);
            frame_height_reg <= dge_pkg::DIM_W'(dge_pkg::MAX_HEIGHT);
        end else if (cfg_wr_en) begin
            if (cfg_index == dge_pkg::CFG_FRAME_WIDTH) begin
                frame_width_reg <= cfg_data;
            end
            if (cfg_index == dge_pkg::CFG_FRAME_HEIGHT) begin
                frame_height_reg <= cfg_data;
            end
        end
    end

    // A size of zero acts as one, a size above the maximum as the maximum.
    always_comb begin
        if (frame_width_reg == '0) begin
            width_eff = dge_pkg::DIM_W'(1);
        end else if (frame_width_reg > dge_pkg::DIM_W'(dge_pkg::MAX_WIDTH)) begin
            width_eff = dge_pkg::DIM_W'(dge_pkg::MAX_WIDTH);
        end else begin
            width_eff = frame_width_reg;
        end
        if (frame_height_reg == '0) begin
            height_eff = dge_pkg::DIM_W'(1);
        end else if (frame_height_reg > dge_pkg::DIM_W'(dge_pkg::MAX_HEIGHT)) begin
            height_eff = dge_pkg::DIM_W'(dge_pkg::MAX_HEIGHT);
        end else begin
            height_eff = frame_height_reg;
        end
        width_last  = width_eff - dge_pkg::DIM_W'(1);
        height_last = height_eff - dge_pkg::DIM_W'(1);
    end

    assign in_frame = ({1'b0, s_row} < height_eff) && ({1'b0, s_col} < width_eff);

    // Classify the beat and work out the wrapped neighbor positions.
    always_comb begin
        q_item.row   = s_row;
        q_item.col   = s_col;
        q_item.pixel = {s_red, s_green, s_blue};
        q_item.col_left  = (s_col == '0) ? width_last[dge_pkg::COL_W-1:0]
                                         : s_col - dge_pkg::COL_W'(1);
        q_item.col_right = ({1'b0, s_col} == width_last) ? '0
                                                         : s_col + dge_pkg::COL_W'(1);
        q_item.row_up    = (s_row == '0) ? height_last[dge_pkg::ROW_W-1:0]
                                         : s_row - dge_pkg::ROW_W'(1);
        q_item.row_down  = ({1'b0, s_row} == height_last) ? '0
                                                          : s_row + dge_pkg::ROW_W'(1);
        case (s_command)
            dge_pkg::CMD_WRITE: begin
                q_item.op = dge_pkg::OP_WRITE;
                keep      = in_frame;
            end
            dge_pkg::CMD_READ: begin
                q_item.op = in_frame ? dge_pkg::OP_READ : dge_pkg::OP_ZERO;
                keep      = 1'b1;
            end
            default: begin
                q_item.op = dge_pkg::OP_ZERO;
                keep      = 1'b1;
            end
        endcase
    end

    // Writes outside the frame are taken and dropped here.
    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready && keep;

endmodule

>>> rtl/dge_queue.sv
module dge_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  dge_pkg::queue_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output dge_pkg::queue_item_t head_item,
    output logic                 empty
);

    dge_pkg::queue_item_t            entries_reg [dge_pkg::QUEUE_DEPTH];
    logic [dge_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [dge_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [dge_pkg::QCNT_W-1:0]      count_reg;
    logic [dge_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [dge_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [dge_pkg::QCNT_W-1:0]      count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full      = (count_reg == dge_pkg::QCNT_W'(dge_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = entries_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == dge_pkg::QPTR_W'(dge_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + dge_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == dge_pkg::QPTR_W'(dge_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + dge_pkg::QPTR_W'(1);
        end
        count_next = count_reg + dge_pkg::QCNT_W'(do_push) - dge_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/dge_back.sv
module dge_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dge_pkg::queue_item_t          q_item,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dge_pkg::ENERGY_W-1:0]  m_energy
);

    localparam int ROOTX_W = dge_pkg::SUM_W + 1;
    localparam int CNT_W   = 3;
    localparam int PROD_W  = dge_pkg::ROOT_W + dge_pkg::DIV10_MUL_W;

    typedef struct packed {
        logic [dge_pkg::SUM_W-1:0] rem;
        logic [ROOTX_W-1:0]        root;
    } sqrt_st_t;

    typedef logic [dge_pkg::SQ_W-1:0] sq_arr_t [3];

    // One bit of the restoring square root.
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t s,
                                           input logic [dge_pkg::SUM_W-1:0] b);
        sqrt_st_t           o;
        logic [ROOTX_W-1:0] trial;
        trial = s.root + {1'b0, b};
        if ({1'b0, s.rem} >= trial) begin
            o.rem  = s.rem - trial[dge_pkg::SUM_W-1:0];
            o.root = (s.root >> 1) + {1'b0, b};
        end else begin
            o.rem  = s.rem;
            o.root = s.root >> 1;
        end
        return o;
    endfunction

    // Absolute channel difference, squared.
    function automatic logic [dge_pkg::SQ_W-1:0] sq_diff(input logic [dge_pkg::CH_W-1:0] x,
                                                         input logic [dge_pkg::CH_W-1:0] y);
        logic [dge_pkg::CH_W-1:0] d;
        d = (x > y) ? x - y : y - x;
        return dge_pkg::SQ_W'(d) * dge_pkg::SQ_W'(d);
    endfunction

    logic [dge_pkg::PIX_W-1:0]    mem [dge_pkg::MEM_DEPTH];
    logic [dge_pkg::PIX_W-1:0]    rd_data_reg;
    logic                         mem_we;
    logic [dge_pkg::ADDR_W-1:0]   mem_addr;

    dge_pkg::back_state_t         state_reg;
    dge_pkg::back_state_t         state_next;
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             cnt_next;
    dge_pkg::queue_item_t         item_reg;
    dge_pkg::queue_item_t         item_next;
    logic [dge_pkg::PIX_W-1:0]    px_a_reg;
    logic [dge_pkg::PIX_W-1:0]    px_a_next;
    sq_arr_t                      sq_reg;
    sq_arr_t                      sq_next;
    logic [dge_pkg::PAIR_W-1:0]   sum_reg;
    logic [dge_pkg::PAIR_W-1:0]   sum_next;
    sqrt_st_t                     sqrt_reg;
    sqrt_st_t                     sqrt_next;
    sqrt_st_t                     sqrt_mid;
    logic [dge_pkg::SUM_W-1:0]    bit_reg;
    logic [dge_pkg::SUM_W-1:0]    bit_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [dge_pkg::ENERGY_W-1:0] energy_reg;
    logic [dge_pkg::ENERGY_W-1:0] energy_next;
    logic [dge_pkg::PAIR_W-1:0]   pair_sum;
    logic [PROD_W-1:0]            div_prod;
    logic                         out_load;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dge_pkg::B_IDLE: begin
                if (!q_empty) begin
                    case (q_item.op)
                        dge_pkg::OP_READ: state_next = dge_pkg::B_FETCH;
                        dge_pkg::OP_ZERO: state_next = dge_pkg::B_OUT;
                        default:          state_next = dge_pkg::B_IDLE;
                    endcase
                end
            end
            dge_pkg::B_FETCH: begin
                if (cnt_reg == CNT_W'(5)) begin
                    state_next = dge_pkg::B_SQRT;
                end
            end
            dge_pkg::B_SQRT: begin
                if (bit_reg[dge_pkg::SUM_W-1:4] == '0) begin
                    state_next = dge_pkg::B_OUT;
                end
            end
            dge_pkg::B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = dge_pkg::B_IDLE;
                end
            end
            default: state_next = dge_pkg::B_IDLE;
        endcase
    end

    // Control outputs: queue pop, memory port and result load
    always_comb begin
        q_pop    = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        mem_addr = {item_reg.row, item_reg.col};
        case (state_reg)
            dge_pkg::B_IDLE: begin
                q_pop    = !q_empty;
                mem_we   = !q_empty && (q_item.op == dge_pkg::OP_WRITE);
                mem_addr = {q_item.row, q_item.col};
            end
            dge_pkg::B_FETCH: begin
                case (cnt_reg)
                    CNT_W'(0): mem_addr = {item_reg.row, item_reg.col_right};
                    CNT_W'(1): mem_addr = {item_reg.row, item_reg.col_left};
                    CNT_W'(2): mem_addr = {item_reg.row_down, item_reg.col};
                    CNT_W'(3): mem_addr = {item_reg.row_up, item_reg.col};
                    default:   mem_addr = {item_reg.row, item_reg.col};
                endcase
            end
            dge_pkg::B_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign pair_sum = dge_pkg::PAIR_W'(sq_reg[0]) + dge_pkg::PAIR_W'(sq_reg[1])
                    + dge_pkg::PAIR_W'(sq_reg[2]);
    assign div_prod = PROD_W'(sqrt_reg.root[dge_pkg::ROOT_W-1:0]) * PROD_W'(dge_pkg::DIV10_MUL);
    assign sqrt_mid = sqrt_step(sqrt_reg, bit_reg);

    // Datapath: neighbor fetch, squared differences, root, divide by ten.
    // Reads go right, left, down, up; each pair is squared from the registered
    // read data of its second pixel and summed in the cycle after that.
    always_comb begin
        cnt_next     = cnt_reg;
        item_next    = item_reg;
        px_a_next    = px_a_reg;
        sq_next      = sq_reg;
        sum_next     = sum_reg;
        sqrt_next    = sqrt_reg;
        bit_next     = bit_reg;
        energy_next  = energy_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            dge_pkg::B_IDLE: begin
                item_next      = q_item;
                cnt_next       = '0;
                sqrt_next.root = '0;
            end
            dge_pkg::B_FETCH: begin
                cnt_next = cnt_reg + CNT_W'(1);
                case (cnt_reg)
                    CNT_W'(1), CNT_W'(3): begin
                        px_a_next = rd_data_reg;
                        if (cnt_reg == CNT_W'(3)) begin
                            sum_next = pair_sum;
                        end
                    end
                    CNT_W'(2), CNT_W'(4): begin
                        sq_next[0] = sq_diff(px_a_reg[23:16], rd_data_reg[23:16]);
                        sq_next[1] = sq_diff(px_a_reg[15:8], rd_data_reg[15:8]);
                        sq_next[2] = sq_diff(px_a_reg[7:0], rd_data_reg[7:0]);
                    end
                    CNT_W'(5): begin
                        sqrt_next.rem  = dge_pkg::SUM_W'(sum_reg) + dge_pkg::SUM_W'(pair_sum);
                        sqrt_next.root = '0;
                        bit_next       = dge_pkg::SUM_W'(1) << (dge_pkg::SUM_W - 1);
                    end
                    default: begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                endcase
            end
            dge_pkg::B_SQRT: begin
                sqrt_next = sqrt_step(sqrt_mid, bit_reg >> 2);
                bit_next  = bit_reg >> 4;
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
        if (out_load) begin
            energy_next  = div_prod[dge_pkg::DIV10_SHIFT +: dge_pkg::ENERGY_W];
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dge_pkg::B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        item_reg   <= item_next;
        px_a_reg   <= px_a_next;
        sq_reg     <= sq_next;
        sum_reg    <= sum_next;
        sqrt_reg   <= sqrt_next;
        bit_reg    <= bit_next;
        energy_reg <= energy_next;
    end

    // Frame memory: one port, registered read data
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= item_next.pixel;
        end
        rd_data_reg <= mem[mem_addr];
    end

    assign m_valid  = m_valid_reg;
    assign m_energy = energy_reg;

endmodule

>>> rtl/dual_gradient_energy_core.sv
// Frame store with dual-gradient energy read-out. A write beat stores one
// RGB pixel at (row, col) and returns nothing; a read beat returns one energy
// value, floor(isqrt(dx2 + dy2) / 10), from the four wrapped neighbors. Beats
// outside the frame set by frame_width and frame_height are dropped (writes)
// or answer 0 (reads). A two-entry queue separates the input side from the
// engine, and a result register separates the engine from the output side.
// The engine stores a write in its dispatch state alone; an out-of-frame read
// goes from dispatch to the result; an energy read goes through dispatch,
// the four neighbor reads through the single port of the frame memory, the
// square root at two bits per cycle and the result. The frame memory is not
// cleared; only positions already written should be read.
module dual_gradient_energy_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dge_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dge_pkg::DIM_W-1:0]           cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [dge_pkg::ROW_W-1:0]           s_row,
    input  logic [dge_pkg::COL_W-1:0]           s_col,
    input  logic [dge_pkg::CH_W-1:0]            s_red,
    input  logic [dge_pkg::CH_W-1:0]            s_green,
    input  logic [dge_pkg::CH_W-1:0]            s_blue,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dge_pkg::ENERGY_W-1:0]        m_energy
);

    dge_pkg::queue_item_t push_item;
    dge_pkg::queue_item_t head_item;
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;

    // Front: configuration, classification and neighbor positions
    dge_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_row     (s_row),
        .s_col     (s_col),
        .s_red     (s_red),
        .s_green   (s_green),
        .s_blue    (s_blue),
        .q_push    (q_push),
        .q_item    (push_item),
        .q_full    (q_full)
    );

    // Work queue
    dge_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    // Back: frame memory and energy engine
    dge_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_item   (head_item),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_energy (m_energy)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_energy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_energy <= dge_pkg::ENERGY_W'(62)))
        else $error("energy above its maximum");

    a_push_after_pop_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_full && !q_pop) |=> !q_empty)
        else $error("full queue lost its entries");
`endif

endmodule
